>>> design/aes_pkg.sv
// AES-128 package: state types, S-box table and GF(2^8) helpers.
// Used by the round cell, the key cell and the top level.
package aes_pkg;

  localparam int BLOCK_W = 128;
  localparam int HALF_W  = 64;

  typedef logic [BLOCK_W-1:0] block_t;

  // Register indexes on the configuration port.
  typedef enum logic [0:0] {
    REG_KEY_HIGH = 1'b0,
    REG_KEY_LOW  = 1'b1
  } reg_idx_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[x];
  endfunction

  function automatic logic [7:0] gf_double(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte k of a block (k = 4*column + row), byte 0 in the top bits.
  function automatic logic [7:0] get_byte(input block_t b, input int k);
    return b[BLOCK_W-1-8*k -: 8];
  endfunction

endpackage

>>> design/aes_key_cell.sv
// AES-128 key cell: one step of the key schedule, registered.
// Depends on aes_pkg for the S-box.
module aes_key_cell
  import aes_pkg::*;
(
  input  logic       clk,
  input  logic       en,
  input  block_t     key_in,
  input  logic [7:0] rcon,
  output block_t     key_out
);

  block_t key_r;
  block_t key_nxt;
  logic [31:0] t;
  logic [31:0] w0, w1, w2, w3;

  always_comb begin
    t = {sbox(key_in[23:16]), sbox(key_in[15:8]), sbox(key_in[7:0]),
         sbox(key_in[31:24])} ^ {rcon, 24'h0};
    w0 = key_in[127:96] ^ t;
    w1 = key_in[95:64] ^ w0;
    w2 = key_in[63:32] ^ w1;
    w3 = key_in[31:0] ^ w2;
    key_nxt = {w0, w1, w2, w3};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      key_r <= key_nxt;
    end
  end

  assign key_out = key_r;

endmodule

>>> design/aes_round_cell.sv
// AES round cell: SubBytes, ShiftRows, optional MixColumns, AddRoundKey.
// Depends on aes_pkg for the S-box and GF helpers.
module aes_round_cell
  import aes_pkg::*;
#(
  parameter bit FINAL = 1'b0
) (
  input  logic   clk,
  input  logic   en,
  input  block_t state_in,
  input  block_t round_key,
  output block_t state_out
);

  block_t state_r;
  block_t state_nxt;
  logic [7:0] sb [16];
  logic [7:0] mc [16];
  logic [7:0] a0, a1, a2, a3, all;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sb[4*c+r] = sbox(get_byte(state_in, 4*((c+r)%4)+r));
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = sb[4*c];
      a1 = sb[4*c+1];
      a2 = sb[4*c+2];
      a3 = sb[4*c+3];
      all = a0 ^ a1 ^ a2 ^ a3;
      if (FINAL) begin
        mc[4*c] = a0;
        mc[4*c+1] = a1;
        mc[4*c+2] = a2;
        mc[4*c+3] = a3;
      end else begin
        mc[4*c]   = a0 ^ all ^ gf_double(a0 ^ a1);
        mc[4*c+1] = a1 ^ all ^ gf_double(a1 ^ a2);
        mc[4*c+2] = a2 ^ all ^ gf_double(a2 ^ a3);
        mc[4*c+3] = a3 ^ all ^ gf_double(a3 ^ a0);
      end
    end
    for (int k = 0; k < 16; k++) begin
      state_nxt[BLOCK_W-1-8*k -: 8] = mc[k] ^ get_byte(round_key, k);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      state_r <= state_nxt;
    end
  end

  assign state_out = state_r;

endmodule

>>> design/aes128_encrypt_block_unit.sv
// AES-128 encryption pipeline top level: a chain of ten round cells with
// a matching chain of key-schedule cells. Depends on aes_pkg, aes_round_cell
// and aes_key_cell.
//
// Usage:
//   in_*  : plaintext beats; plain_high sits in tdata bits 63:0 and plain_low
//           in bits 127:64.
//   out_* : ciphertext beats; cipher_high in bits 63:0, cipher_low in 127:64.
//   cfg_* : key writes, index 0 is key_high and index 1 is key_low. Write
//           keys only while idle.
// Pipeline: an accepted input beat passes one register stage for the initial
// key add, then one per round cell, to its output beat. Throughput is one
// block per cycle: the chain advances whenever the output stage is empty or
// being drained, so the number of rounds sets latency and not rate.
// The round keys travel down the key chain beside their block, so each
// round cell sees its own round key in the same cycle as its data.
// Reset clears the stage valid bits and the cipher-key registers to zero.
// When the receiver stalls, the whole chain holds; in_tready drops until
// out_tready returns, so no beat is lost or repeated.
module aes128_encrypt_block_unit
  import aes_pkg::*;
#(
  parameter int NUM_ROUNDS = 10
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // [63:0] plain_high, [127:64] plain_low
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // [63:0] cipher_high, [127:64] cipher_low
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [0:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  logic [63:0] key_high_r, key_low_r;
  logic [NUM_ROUNDS:0] vld_r;
  logic adv;
  block_t st [NUM_ROUNDS+1];
  block_t rk [NUM_ROUNDS+1];
  block_t st0_r, rk0_r;
  logic [7:0] rcon [NUM_ROUNDS];

  // The chain moves as a whole when the last stage is free or drained.
  assign adv = !vld_r[NUM_ROUNDS] || out_tready;
  assign in_tready = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r <= '0;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_KEY_HIGH: key_high_r <= cfg_data;
        REG_KEY_LOW:  key_low_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NUM_ROUNDS-1:0], in_tvalid};
    end
  end

  // Stage zero: initial AddRoundKey, and the cipher key enters the key chain.
  // Inside the chain the block is held with plain_high in the top half.
  always_ff @(posedge clk) begin
    if (adv) begin
      st0_r <= {in_tdata[63:0], in_tdata[127:64]} ^ {key_high_r, key_low_r};
      rk0_r <= {key_high_r, key_low_r};
    end
  end

  assign st[0] = st0_r;
  assign rk[0] = rk0_r;

  always_comb begin
    rcon[0] = 8'h01;
    for (int i = 1; i < NUM_ROUNDS; i++) begin
      rcon[i] = gf_double(rcon[i-1]);
    end
  end

  // Key cell i and round cell i register in the same cycle; the round cell
  // uses its own copy of the next key, computed beside the key cell.
  for (genvar i = 0; i < NUM_ROUNDS; i++) begin : g_chain
    block_t nk;
    logic [31:0] t, w0, w1, w2, w3;
    always_comb begin
      t = {sbox(rk[i][23:16]), sbox(rk[i][15:8]), sbox(rk[i][7:0]),
           sbox(rk[i][31:24])} ^ {rcon[i], 24'h0};
      w0 = rk[i][127:96] ^ t;
      w1 = rk[i][95:64] ^ w0;
      w2 = rk[i][63:32] ^ w1;
      w3 = rk[i][31:0] ^ w2;
      nk = {w0, w1, w2, w3};
    end
    aes_key_cell u_key (
      .clk(clk), .en(adv), .key_in(rk[i]), .rcon(rcon[i]), .key_out(rk[i+1])
    );
    aes_round_cell #(.FINAL(i == NUM_ROUNDS-1)) u_round (
      .clk(clk), .en(adv), .state_in(st[i]), .round_key(nk),
      .state_out(st[i+1])
    );
  end

  assign out_tvalid = vld_r[NUM_ROUNDS];
  assign out_tdata = {st[NUM_ROUNDS][63:0], st[NUM_ROUNDS][127:64]};

endmodule

>>> design/aes_checker.sv
// Port-level checker for aes128_encrypt_block_unit, bound to the top level.
// Depends only on the top level's ports.
module aes_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [127:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output beat changed while stalled");

  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input accepted while chain is stalled");

  a_free_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input refused with an empty output stage");

  a_no_spurious: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule

bind aes128_encrypt_block_unit aes_checker u_aes_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);

>>> verif/tb_aes128_encrypt_block_unit.sv
// Self-checking testbench for the AES-128 encryption pipeline.
// It predicts each ciphertext with a behavioral AES-128 model and needs only
// aes_pkg and aes128_encrypt_block_unit.
`timescale 1ns / 100ps

module tb_aes128_encrypt_block_unit;
  import aes_pkg::*;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
  } cipher_beat_t;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 16;   // a little over the pipeline latency

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [0:0]   cfg_index = REG_KEY_HIGH;
  logic [63:0]  cfg_data = '0;

  // Plaintext blocks waiting to be offered, and ciphertexts still owed.
  // A pending block holds plain_high in its top half.
  logic [127:0] plain_pending[$];
  cipher_beat_t cipher_owed[$];

  // The key as the testbench believes the block holds it.
  logic [63:0] key_high_copy = '0;
  logic [63:0] key_low_copy = '0;

  // Idle rates in percent for each side; changed by the sequencer per phase.
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  int unsigned hold_len = 0;
  logic        hold_req = 1'b0;

  logic [7:0] sub_table[256];
  int         fail_count = 0;
  int         quiet_cycles = 0;
  logic       in_taken = 1'b0;

  aes128_encrypt_block_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Behavioral AES-128. The S-box is derived rather than tabulated: the
  // multiplicative inverse in GF(2^8) followed by the FIPS-197 affine map.
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] aa;
    acc = '0;
    aa = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= aa;
      aa = xtime(aa);
    end
    return acc;
  endfunction

  initial begin
    logic [7:0] inv;
    for (int x = 0; x < 256; x++) begin
      inv = '0;
      for (int y = 1; y < 256; y++) begin
        if (gf_mul(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
      end
      sub_table[x] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^
                     {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
    end
  end

  function automatic cipher_beat_t encrypt_block(input logic [127:0] key,
                                                 input logic [127:0] plain);
    logic [7:0]  st[16];
    logic [7:0]  tmp[16];
    logic [31:0] rk[4];
    logic [31:0] t;
    logic [7:0]  rcon;
    logic [7:0]  a0, a1, a2, a3, all;
    logic [127:0] res;
    for (int k = 0; k < 16; k++) st[k] = plain[127-8*k -: 8];
    for (int c = 0; c < 4; c++) rk[c] = key[127-32*c -: 32];
    rcon = 8'h01;
    for (int rnd = 0; rnd <= 10; rnd++) begin
      if (rnd > 0) begin
        // SubBytes and ShiftRows in one pass: row r rotates left by r columns.
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++)
            tmp[4*c+r] = sub_table[st[4*((c+r)%4)+r]];
        st = tmp;
        if (rnd < 10) begin
          for (int c = 0; c < 4; c++) begin
            a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
            all = a0 ^ a1 ^ a2 ^ a3;
            st[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
            st[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
            st[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
            st[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
          end
        end
        // Next round key, computed on the fly from the previous one.
        t = {rk[3][23:0], rk[3][31:24]};
        t = {sub_table[t[31:24]], sub_table[t[23:16]],
             sub_table[t[15:8]], sub_table[t[7:0]]} ^ {rcon, 24'h0};
        rcon = xtime(rcon);
        rk[0] ^= t;
        rk[1] ^= rk[0];
        rk[2] ^= rk[1];
        rk[3] ^= rk[2];
      end
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          st[4*c+r] ^= rk[c][31-8*r -: 8];
    end
    for (int k = 0; k < 16; k++) res[127-8*k -: 8] = st[k];
    return '{cipher_high: res[127:64], cipher_low: res[63:0]};
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver. A beat that was offered stays on the bus until it is taken;
  // only then may the next one (or an idle cycle) follow. On the bus
  // plain_high travels in the low half of tdata.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    in_taken <= in_tvalid && in_tready;
    if (in_tvalid && in_tready)
      cipher_owed.push_back(encrypt_block({key_high_copy, key_low_copy},
                                          {in_tdata[63:0], in_tdata[127:64]}));
  end

  always @(negedge clk) begin
    logic [127:0] next_plain;
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (plain_pending.size() > 0 && $urandom_range(99) >= send_idle) begin
        next_plain = plain_pending.pop_front();
        in_tdata  <= {next_plain[63:0], next_plain[127:64]};
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver. A toggle of hold_req starts a long hold-off, counted here, so
  // the pipeline fills and pushes back on the input side.
  // ---------------------------------------------------------------------------
  logic hold_seen = 1'b0;
  int   hold_left = 0;

  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen  <= hold_req;
      hold_left  <= hold_len;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= rst_n && ($urandom_range(99) >= recv_idle);
    end
  end

  // Ciphertext checker: every beat must match the oldest owed result.
  // cipher_high travels in the low half of tdata.
  always @(posedge clk) begin
    cipher_beat_t want;
    if (out_tvalid && out_tready) begin
      if (cipher_owed.size() == 0) begin
        $error("unexpected ciphertext beat %h", out_tdata);
        fail_count++;
      end else begin
        want = cipher_owed.pop_front();
        if (out_tdata[63:0] !== want.cipher_high) begin
          $error("cipher_high expected %h actual %h", want.cipher_high, out_tdata[63:0]);
          fail_count++;
        end
        if (out_tdata[127:64] !== want.cipher_low) begin
          $error("cipher_low expected %h actual %h", want.cipher_low, out_tdata[127:64]);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: any handshake on any channel counts as progress.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------------
  task automatic write_key_reg(input reg_idx_t idx, input logic [63:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_KEY_HIGH) key_high_copy = value;
    else key_low_copy = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Waits until every block has been offered, taken and answered, then lets
  // the pipeline settle before anything else changes.
  task automatic drain_pipeline();
    do @(posedge clk);
    while (plain_pending.size() > 0 || in_tvalid || cipher_owed.size() > 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [127:0] random_block();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  task automatic queue_random(input int count);
    for (int i = 0; i < count; i++) plain_pending.push_back(random_block());
  endtask

  task automatic queue_corners();
    plain_pending.push_back('0);
    plain_pending.push_back('1);
    plain_pending.push_back({64'h0, 64'hffff_ffff_ffff_ffff});
    plain_pending.push_back({64'hffff_ffff_ffff_ffff, 64'h0});
    plain_pending.push_back({32{4'h5}});
    plain_pending.push_back({32{4'ha}});
    plain_pending.push_back(128'h0011_2233_4455_6677_8899_aabb_ccdd_eeff);
    plain_pending.push_back(128'h1);
    plain_pending.push_back(128'h1 << 127);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Phase 1: the all-zero key left by reset, corner plaintexts, sender
    // idling lightly and receiver heavily.
    send_idle = 17;
    recv_idle = 47;
    queue_corners();
    drain_pipeline();

    // Phase 2: the standard example key, including its known test block.
    // The receiver first holds off for a long stretch while the sender keeps
    // offering, so the pipeline fills and stalls the input.
    write_key_reg(REG_KEY_HIGH, 64'h0001_0203_0405_0607);
    write_key_reg(REG_KEY_LOW, 64'h0809_0a0b_0c0d_0e0f);
    hold_len = 150;
    hold_req = ~hold_req;
    queue_corners();
    queue_random(300);
    drain_pipeline();

    // Phase 3: the all-ones key with the idle rates swapped.
    send_idle = 47;
    recv_idle = 17;
    write_key_reg(REG_KEY_HIGH, 64'hffff_ffff_ffff_ffff);
    write_key_reg(REG_KEY_LOW, 64'hffff_ffff_ffff_ffff);
    plain_pending.push_back('0);
    plain_pending.push_back('1);
    queue_random(300);
    drain_pipeline();

    // Phase 4: random keys at full rate on both sides, so back-to-back beats
    // stream through the pipeline with no gaps.
    send_idle = 0;
    recv_idle = 0;
    for (int phase = 0; phase < 4; phase++) begin
      write_key_reg(REG_KEY_HIGH, {$urandom, $urandom});
      write_key_reg(REG_KEY_LOW, {$urandom, $urandom});
      queue_random(100);
      drain_pipeline();
    end

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
